### hw/rtl/ntc_table_temperature_interp_top_macros.svh
// Assertion macros for the thermistor lookup RTL.
`ifndef NTC_TABLE_TEMPERATURE_INTERP_TOP_MACROS_SVH
`define NTC_TABLE_TEMPERATURE_INTERP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NTC_TI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ntc_ti assertion failed");
`define NTC_TI_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ntc_ti assertion failed");
`else
`define NTC_TI_ASSERT(lbl, prop)
`define NTC_TI_ASSERT_NR(lbl, prop)
`endif
`endif

### hw/rtl/ntc_ti_pkg.sv
// Constants and the ADC grid table of the thermistor temperature lookup.
`timescale 1ns / 1ps
package ntc_ti_pkg;

  localparam int TABLE_ENTRIES = 31;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int GRID_STEP     = 50;
  localparam int TEMP_WIDTH    = 11;
  localparam int TEMP_MIN      = 0;
  localparam int TEMP_MAX      = (TABLE_ENTRIES - 1) * GRID_STEP;

  localparam int IDX_W  = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int QUOT_W = $clog2(GRID_STEP + 1);
  localparam int NUM_W  = SAMPLE_WIDTH + QUOT_W + 1;
  localparam int BASE_W = $clog2(TEMP_MAX + 1);
  localparam int SEARCH_STAGES = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES - 1) : 1;

  // ADC sums, descending, one per grid step starting at 0.0 C
  localparam logic [SAMPLE_WIDTH-1:0] ADC_GRID [TABLE_ENTRIES] = '{
    16'd50782, 16'd48085, 16'd45204, 16'd42192, 16'd39107, 16'd36009, 16'd32956, 16'd29999,
    16'd27178, 16'd24524, 16'd22058, 16'd19790, 16'd17722, 16'd15850, 16'd14166, 16'd12658,
    16'd11313, 16'd10117, 16'd9054,  16'd8112,  16'd7277,  16'd6538,  16'd5883,  16'd5302,
    16'd4787,  16'd4329,  16'd3923,  16'd3560,  16'd3238,  16'd2950,  16'd2692
  };

endpackage

### hw/rtl/ntc_ti_adc_if.sv
// Stream interface carrying one ADC sum item.
`timescale 1ns / 1ps
interface ntc_ti_adc_if
  import ntc_ti_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] adc_sum;

  modport source (output valid, output adc_sum, input ready);
  modport sink   (input valid, input adc_sum, output ready);
endinterface

### hw/rtl/ntc_ti_temp_if.sv
// Stream interface carrying one temperature item.
`timescale 1ns / 1ps
interface ntc_ti_temp_if
  import ntc_ti_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [TEMP_WIDTH-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

### hw/rtl/ntc_table_temperature_interp_top.sv
// Thermistor ADC sum to temperature converter: table search and interpolation pipeline.
//
// Converts a 16-bit summed thermistor reading into tenths of a degree C (0..1500).
// The item passes an input register, a binary search over the ADC grid (one step per
// stage, 5 stages), a neighbor fetch stage, a scale stage (multiply by the grid step),
// a restoring divider with one quotient bit per stage (6 stages) and the output
// register. A new item may enter every cycle unless a result waits untaken.
// When the result is not taken, the whole pipeline holds and stops taking items.
`timescale 1ns / 1ps
`include "ntc_table_temperature_interp_top_macros.svh"
module ntc_table_temperature_interp_top
  import ntc_ti_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ntc_ti_adc_if.sink    sample_i,
  ntc_ti_temp_if.source temp_o
);

  localparam int S_PREP  = SEARCH_STAGES + 1;
  localparam int S_SCALE = SEARCH_STAGES + 2;
  localparam int S_DIV   = SEARCH_STAGES + 3;
  localparam int STAGES  = S_DIV + QUOT_W;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] x;
    logic [IDX_W-1:0]        lo;
    logic [IDX_W-1:0]        hi;
    logic                    clamp_hot;
    logic                    clamp_cold;
    logic                    exact;
    logic                    span_zero;
    logic [SAMPLE_WIDTH-1:0] span;
    logic [NUM_W-1:0]        rem;
    logic [QUOT_W-1:0]       quot;
  } pipe_t;

  pipe_t                 pipe_d [STAGES];
  pipe_t                 pipe_q [STAGES];
  logic [STAGES-1:0]     valid_q;
  logic                  out_valid_q;
  logic [TEMP_WIDTH-1:0] temp_d, temp_q;
  logic                  en;

  assign en             = !out_valid_q || temp_o.ready;
  assign sample_i.ready = en;
  assign temp_o.valid   = out_valid_q;
  assign temp_o.temperature = temp_q;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k == 0) begin : g_in
      always_comb begin
        pipe_d[k]            = '0;
        pipe_d[k].x          = sample_i.adc_sum;
        pipe_d[k].clamp_hot  = sample_i.adc_sum <= ADC_GRID[TABLE_ENTRIES-1];
        pipe_d[k].clamp_cold = sample_i.adc_sum >= ADC_GRID[0];
        pipe_d[k].lo         = '0;
        pipe_d[k].hi         = IDX_W'(TABLE_ENTRIES - 1);
      end
    end else if (k <= SEARCH_STAGES) begin : g_search
      logic [IDX_W:0]   sum;
      logic [IDX_W-1:0] mid;
      logic [IDX_W-1:0] gap;
      assign sum = {1'b0, pipe_q[k-1].lo} + {1'b0, pipe_q[k-1].hi};
      assign mid = sum[IDX_W:1];
      assign gap = pipe_q[k-1].hi - pipe_q[k-1].lo;
      always_comb begin
        pipe_d[k] = pipe_q[k-1];
        if (gap > IDX_W'(1)) begin
          if (pipe_q[k-1].x > ADC_GRID[mid]) begin
            pipe_d[k].hi = mid;
          end else begin
            pipe_d[k].lo = mid;
          end
        end
      end
    end else if (k == S_PREP) begin : g_prep
      logic [SAMPLE_WIDTH-1:0] v_lo, v_hi;
      assign v_lo = ADC_GRID[pipe_q[k-1].lo];
      assign v_hi = ADC_GRID[pipe_q[k-1].hi];
      always_comb begin
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].exact = pipe_q[k-1].x >= v_lo;
        pipe_d[k].span  = v_lo - v_hi;
        pipe_d[k].rem   = NUM_W'(pipe_q[k-1].x - v_hi);
      end
    end else if (k == S_SCALE) begin : g_scale
      always_comb begin
        pipe_d[k]           = pipe_q[k-1];
        pipe_d[k].span_zero = pipe_q[k-1].span == '0;
        pipe_d[k].rem       = NUM_W'(pipe_q[k-1].rem * NUM_W'(GRID_STEP))
                            + NUM_W'(pipe_q[k-1].span >> 1);
      end
    end else begin : g_div
      localparam int B = QUOT_W - 1 - (k - S_DIV);
      logic [NUM_W-1:0] dvs;
      assign dvs = NUM_W'(pipe_q[k-1].span) << B;
      always_comb begin
        pipe_d[k] = pipe_q[k-1];
        if (pipe_q[k-1].rem >= dvs) begin
          pipe_d[k].rem     = pipe_q[k-1].rem - dvs;
          pipe_d[k].quot[B] = 1'b1;
        end
      end
    end
  end

  logic [BASE_W-1:0] base_lo, base_hi;
  assign base_lo = BASE_W'(pipe_q[STAGES-1].lo * GRID_STEP);
  assign base_hi = BASE_W'(pipe_q[STAGES-1].hi * GRID_STEP);

  always_comb begin
    if (pipe_q[STAGES-1].clamp_hot) begin
      temp_d = TEMP_WIDTH'(TEMP_MAX);
    end else if (pipe_q[STAGES-1].clamp_cold) begin
      temp_d = TEMP_WIDTH'(TEMP_MIN);
    end else if (pipe_q[STAGES-1].exact) begin
      temp_d = TEMP_WIDTH'(base_lo);
    end else if (pipe_q[STAGES-1].span_zero) begin
      temp_d = TEMP_WIDTH'(base_hi);
    end else begin
      temp_d = TEMP_WIDTH'(base_hi - BASE_W'(pipe_q[STAGES-1].quot));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[STAGES-2:0], sample_i.valid};
      out_valid_q <= valid_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
      temp_q <= temp_d;
    end
  end

  `NTC_TI_ASSERT(a_enter, sample_i.valid && sample_i.ready |=> valid_q[0])
  `NTC_TI_ASSERT(a_hold, temp_o.valid && !temp_o.ready |=> $stable(valid_q))
  `NTC_TI_ASSERT(a_bracket, valid_q[SEARCH_STAGES] && !pipe_q[SEARCH_STAGES].clamp_hot && !pipe_q[SEARCH_STAGES].clamp_cold |-> pipe_q[SEARCH_STAGES].hi == IDX_W'(pipe_q[SEARCH_STAGES].lo + 1'b1))
  `NTC_TI_ASSERT(a_range, temp_o.valid |-> temp_o.temperature <= TEMP_WIDTH'(TEMP_MAX))
  `NTC_TI_ASSERT_NR(a_rst_idle, !rst_ni |=> !temp_o.valid)

endmodule
